/* rtl/assert_macros.svh */
// Assertion macros for the RTL files that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge of clk once out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When cond holds at an edge, prop must hold at that same edge
`define ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

`endif

/* rtl/elx_pkg.sv */
// Types, character constants and classification functions of the expression lexer
`timescale 1ns / 1ps
package elx_pkg;

  localparam int LEN_BITS   = 16;
  localparam int OUT_BITS   = 16;
  localparam int LEAD_CHARS = 4;
  localparam int MAX_TOKENS = 3;

  localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

  // Characters the lexer cares about
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_EQUAL      = 8'h3D;
  localparam logic [7:0] CH_SEMI       = 8'h3B;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7A;
  localparam logic [7:0] CH_UPPER_A    = 8'h41;
  localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LOWER_I    = 8'h69;
  localparam logic [7:0] CH_LOWER_F    = 8'h66;
  localparam logic [7:0] CH_LOWER_E    = 8'h65;
  localparam logic [7:0] CH_LOWER_L    = 8'h6C;
  localparam logic [7:0] CH_LOWER_S    = 8'h73;

  localparam logic [LEN_BITS-1:0] LEN_IF   = 16'd2;
  localparam logic [LEN_BITS-1:0] LEN_ELSE = 16'd4;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    KIND_IDENT   = 4'd0,
    KIND_NUMBER  = 4'd1,
    KIND_PLUS    = 4'd2,
    KIND_MINUS   = 4'd3,
    KIND_STAR    = 4'd4,
    KIND_SLASH   = 4'd5,
    KIND_LPAREN  = 4'd6,
    KIND_RPAREN  = 4'd7,
    KIND_EQUAL   = 4'd8,
    KIND_SEMI    = 4'd9,
    KIND_IF      = 4'd10,
    KIND_ELSE    = 4'd11,
    KIND_END     = 4'd12,
    KIND_INVALID = 4'd13
  } kind_t;

  typedef logic [LEAD_CHARS-1:0][7:0] lead_t;

  typedef struct packed {
    kind_t               kind;
    logic [OUT_BITS-1:0] start;
    logic [LEN_BITS-1:0] length;
    logic                last;
  } tok_t;

  // Tokens caused by one input word, in delivery order
  typedef struct packed {
    tok_t [MAX_TOKENS-1:0] slot;
    logic [1:0]            count;
  } tok_batch_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // C-locale whitespace: space, TAB, LF, VT, FF, CR
  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic kind_t op_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_PLUS:   k = KIND_PLUS;
      CH_MINUS:  k = KIND_MINUS;
      CH_STAR:   k = KIND_STAR;
      CH_SLASH:  k = KIND_SLASH;
      CH_LPAREN: k = KIND_LPAREN;
      CH_RPAREN: k = KIND_RPAREN;
      CH_EQUAL:  k = KIND_EQUAL;
      CH_SEMI:   k = KIND_SEMI;
      default:   k = KIND_INVALID;
    endcase
    return k;
  endfunction

  // Identifier kind, with keyword match on the stored leading characters
  function automatic kind_t ident_kind(input logic [LEN_BITS-1:0] len, input lead_t lead);
    kind_t k;
    k = KIND_IDENT;
    if (len == LEN_IF && lead[0] == CH_LOWER_I && lead[1] == CH_LOWER_F) begin
      k = KIND_IF;
    end else if (len == LEN_ELSE && lead[0] == CH_LOWER_E && lead[1] == CH_LOWER_L &&
                 lead[2] == CH_LOWER_S && lead[3] == CH_LOWER_E) begin
      k = KIND_ELSE;
    end
    return k;
  endfunction

endpackage

/* rtl/expression_lexer.sv */
// Expression lexer top level: input register, lexer core and token buffer
// The first token of a byte is registered in the input register, then in the token buffer.
// Throughput: one byte per cycle while each byte yields at most one token and out_ready
//   is high; a byte that yields more tokens holds the input while they drain through the one-word output port.
// Reset: synchronous active-low rst_n empties both registers and returns the
//   lexer to idle at offset zero.
`timescale 1ns / 1ps
module expression_lexer import elx_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                in_end_of_input,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_token_kind,
  output logic [OUT_BITS-1:0] out_token_start,
  output logic [LEN_BITS-1:0] out_token_length,
  output logic                out_last_result
);

`include "assert_macros.svh"

  logic       in_valid_r;
  logic [7:0] ch_r;
  logic       eoi_r;
  logic       room;
  logic       commit;
  tok_batch_t batch;
  tok_t       head;

  assign commit   = in_valid_r && room;
  assign in_ready = !in_valid_r || commit;

  // Input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_valid_r <= 1'b1;
    end else if (commit) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r  <= in_ch;
      eoi_r <= in_end_of_input;
    end
  end

  elx_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .commit(commit),
    .ch    (ch_r),
    .eoi   (eoi_r),
    .batch (batch)
  );

  elx_tok_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (commit),
    .batch    (batch),
    .out_ready(out_ready),
    .room     (room),
    .out_valid(out_valid),
    .head     (head)
  );

  assign out_token_kind   = head.kind;
  assign out_token_start  = head.start;
  assign out_token_length = head.length;
  assign out_last_result  = head.last;

  // Nothing waiting at the output means the input side takes a word
  `ASSERT_IMPLY(a_ready_when_empty, !out_valid, in_ready, "input blocked with empty buffer")
  // The end token closes the tokens of its byte
  `ASSERT_IMPLY(a_end_is_last, out_valid && out_token_kind == KIND_END, out_last_result,
                "end token not marked last")
  // The end token has no characters
  `ASSERT_IMPLY(a_end_len_zero, out_valid && out_token_kind == KIND_END,
                out_token_length == '0, "end token with nonzero length")

endmodule

/* rtl/elx_core.sv */
// Lexer state and the per-word token builder
`timescale 1ns / 1ps
module elx_core import elx_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       commit,
  input  logic [7:0] ch,
  input  logic       eoi,
  output tok_batch_t batch
);

  localparam int PB = POSITION_BITS;

  mode_t               mode_r, mode_nxt;
  logic [PB-1:0]       pos_r, pos_nxt;
  logic [PB-1:0]       run_start_r, run_start_nxt;
  logic [LEN_BITS-1:0] run_len_r, run_len_nxt;
  lead_t               lead_r, lead_nxt;

  // Offsets wider than the output field report as all ones
  function automatic logic [OUT_BITS-1:0] sat_pos(input logic [PB-1:0] v);
    logic [PB+OUT_BITS-1:0] e;
    e = {{OUT_BITS{1'b0}}, v};
    return (e[PB+OUT_BITS-1:OUT_BITS] != '0) ? '1 : e[OUT_BITS-1:0];
  endfunction

  logic                letter, digit, space, extended, in_run;
  mode_t               mode1;
  logic [PB-1:0]       rs1, pos1;
  logic [LEN_BITS-1:0] rl1;
  lead_t               lead1;
  tok_t [3:0]          cand;
  logic [3:0]          cand_v;
  tok_t [3:0]          lst;
  logic [2:0]          n;

  assign letter = is_letter(ch);
  assign digit  = is_digit(ch);
  assign space  = is_space(ch);
  assign in_run = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER);

  // Extend, close or open a run with this character
  always_comb begin
    extended = 1'b0;
    mode1    = mode_r;
    rs1      = run_start_r;
    rl1      = run_len_r;
    lead1    = lead_r;
    case (mode_r)
      MODE_IDENT:  extended = letter || digit;
      MODE_NUMBER: extended = digit;
      default:     extended = 1'b0;
    endcase
    if (extended) begin
      if (mode_r == MODE_IDENT && run_len_r < LEN_BITS'(LEAD_CHARS)) begin
        lead1[run_len_r[1:0]] = ch;
      end
      if (run_len_r != LEN_MAX) begin
        rl1 = run_len_r + LEN_BITS'(1);
      end
    end else if (letter) begin
      mode1    = MODE_IDENT;
      rs1      = pos_r;
      rl1      = LEN_BITS'(1);
      lead1[0] = ch;
    end else if (digit) begin
      mode1 = MODE_NUMBER;
      rs1   = pos_r;
      rl1   = LEN_BITS'(1);
    end else begin
      mode1 = MODE_IDLE;
    end
    pos1 = (pos_r == '1) ? pos_r : pos_r + PB'(1);
  end

  // Candidate tokens in output order: closed run, operator, run closed by end, end
  always_comb begin
    cand_v[0]      = !extended && in_run;
    cand[0].kind   = (mode_r == MODE_IDENT) ? ident_kind(run_len_r, lead_r) : KIND_NUMBER;
    cand[0].start  = sat_pos(run_start_r);
    cand[0].length = run_len_r;
    cand[0].last   = 1'b0;

    cand_v[1]      = !extended && !letter && !digit && !space;
    cand[1].kind   = op_kind(ch);
    cand[1].start  = sat_pos(pos_r);
    cand[1].length = LEN_BITS'(1);
    cand[1].last   = 1'b0;

    cand_v[2]      = eoi && (mode1 == MODE_IDENT || mode1 == MODE_NUMBER);
    cand[2].kind   = (mode1 == MODE_IDENT) ? ident_kind(rl1, lead1) : KIND_NUMBER;
    cand[2].start  = sat_pos(rs1);
    cand[2].length = rl1;
    cand[2].last   = 1'b0;

    cand_v[3]      = eoi;
    cand[3].kind   = KIND_END;
    cand[3].start  = sat_pos(pos1);
    cand[3].length = '0;
    cand[3].last   = 1'b0;
  end

  // Pack the valid candidates; at most three are ever valid together
  always_comb begin
    lst = cand;
    n   = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i]) begin
        lst[n[1:0]] = cand[i];
        n = n + 3'd1;
      end
    end
    for (int i = 0; i < MAX_TOKENS; i++) begin
      lst[i].last = (3'(i) == n - 3'd1);
    end
    batch.slot  = lst[MAX_TOKENS-1:0];
    batch.count = n[1:0];
  end

  // Next state; end of input returns to idle at offset zero
  always_comb begin
    lead_nxt = lead1;
    if (eoi) begin
      mode_nxt      = MODE_IDLE;
      pos_nxt       = '0;
      run_start_nxt = '0;
      run_len_nxt   = '0;
    end else begin
      mode_nxt      = mode1;
      pos_nxt       = pos1;
      run_start_nxt = rs1;
      run_len_nxt   = rl1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pos_r       <= '0;
      run_start_r <= '0;
      run_len_r   <= '0;
    end else if (commit) begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      run_start_r <= run_start_nxt;
      run_len_r   <= run_len_nxt;
    end
  end

  // Leading characters: only entries below the run length are ever read
  always_ff @(posedge clk) begin
    if (commit) begin
      lead_r <= lead_nxt;
    end
  end

endmodule

/* rtl/elx_tok_buf.sv */
// Three-entry token buffer that drains one word per cycle to the output while out_ready is high
`timescale 1ns / 1ps
module elx_tok_buf import elx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  tok_batch_t batch,
  input  logic       out_ready,
  output logic       room,
  output logic       out_valid,
  output tok_t       head
);

  tok_t [MAX_TOKENS-1:0] slot_r;
  logic [1:0]            cnt_r;
  logic                  pop;

  assign out_valid = (cnt_r != 2'd0);
  assign head      = slot_r[0];
  assign pop       = out_valid && out_ready;
  // A new batch fits once the buffer is empty at this edge
  assign room      = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  // Count of waiting tokens
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= batch.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // Token slots, head at entry 0
  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= batch.slot;
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
      slot_r[1] <= slot_r[2];
    end
  end

endmodule
